FILE: rtl/core/servo_write_packet_framer_unit_assert.svh
// Assertion macros shared by the servo write packet framer checkers.
// Depends on nothing; included by the checker file.
`ifndef SERVO_WRITE_PACKET_FRAMER_UNIT_ASSERT_SVH
`define SERVO_WRITE_PACKET_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication; the consequent may start with a fixed delay.
`define SWPF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("servo framer check failed");

// Next-cycle implication.
`define SWPF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("servo framer check failed");

`endif

FILE: rtl/core/swpf_pkg.sv
// Shared types, constants and the microcode table of the servo write packet framer.
// Depends on nothing; imported by every framer module.
`default_nettype none

package swpf_pkg;

   localparam int MAX_DATA     = 4;
   localparam int DATA_FIELDS  = 4;
   localparam int CNT_W        = $clog2(MAX_DATA + 1);
   localparam int STEP_W       = 3;
   localparam int ADDR_W       = 3;

   localparam logic [7:0] HDR_BYTE     = 8'hFF;
   localparam logic [7:0] WRITE_INSTR  = 8'h03;
   localparam logic [7:0] LEN_OVERHEAD = 8'd3;

   // Register index of device_id, taken from paddr bit 2.
   localparam logic REG_DEVICE_ID = 1'b0;
   localparam logic [7:0] DEVICE_ID_RESET = 8'd1;

   typedef enum logic [2:0] {
      SEL_HDR,
      SEL_ID,
      SEL_LEN,
      SEL_INSTR,
      SEL_ADDR,
      SEL_DATA,
      SEL_CSUM
   } byte_sel_type;

   typedef enum logic [1:0] {
      SUM_HOLD,
      SUM_LOAD,
      SUM_ADD
   } sum_op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_SKIP_EMPTY,
      BR_LOOP,
      BR_END
   } branch_type;

   typedef struct packed {
      byte_sel_type       sel;
      sum_op_type         sum_op;
      logic               last;
      branch_type         branch;
      logic [STEP_W-1:0]  target;
   } ucode_type;

   typedef struct packed {
      logic no_data;
      logic more_data;
   } flags_type;

   typedef struct packed {
      logic      load;
      logic      run;
      ucode_type uc;
   } dp_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_DATA = 3'd6;
   localparam logic [STEP_W-1:0] STEP_CSUM = 3'd7;

   // One control word per packet byte; the data step repeats per data byte.
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{SEL_HDR, SUM_HOLD, 1'b0, BR_NEXT, '0};
      case (step)
         3'd0: w = '{SEL_HDR,   SUM_HOLD, 1'b0, BR_NEXT,       '0};
         3'd1: w = '{SEL_HDR,   SUM_HOLD, 1'b0, BR_NEXT,       '0};
         3'd2: w = '{SEL_ID,    SUM_LOAD, 1'b0, BR_NEXT,       '0};
         3'd3: w = '{SEL_LEN,   SUM_ADD,  1'b0, BR_NEXT,       '0};
         3'd4: w = '{SEL_INSTR, SUM_ADD,  1'b0, BR_NEXT,       '0};
         3'd5: w = '{SEL_ADDR,  SUM_ADD,  1'b0, BR_SKIP_EMPTY, STEP_CSUM};
         3'd6: w = '{SEL_DATA,  SUM_ADD,  1'b0, BR_LOOP,       STEP_DATA};
         3'd7: w = '{SEL_CSUM,  SUM_HOLD, 1'b1, BR_END,        '0};
         default: w = '{SEL_CSUM, SUM_HOLD, 1'b1, BR_END, '0};
      endcase
      return w;
   endfunction

   function automatic logic [CNT_W-1:0] sat_count(input logic [2:0] count);
      if (int'(count) > MAX_DATA) begin
         return CNT_W'(MAX_DATA);
      end
      return CNT_W'(count);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/servo_write_packet_framer_unit.sv
// Top level of the servo bus write packet framer.
// Depends on swpf_pkg, swpf_csr, swpf_sequencer and swpf_datapath.
`default_nettype none

// A request (register address, data count and up to four data bytes) is taken
// at a rising edge where start is high and busy is low. The framer then sends
// the whole servo bus write packet, one byte per beat on rsp_packet_byte with
// rsp_valid high for that one cycle: 0xFF, 0xFF, device_id, count+3, 0x03,
// the register address, the data bytes and the checksum, which is the inverse
// of the 8-bit sum of device_id through the last data byte and is the only
// beat with rsp_last_byte set. A count above MAX_DATA is cut to MAX_DATA and a
// count of zero sends no data bytes. The receiver cannot stall: every beat
// shows for exactly one cycle and must be captured then. A request of n data
// bytes takes one step of the microcode sequencer per packet byte, and the
// first byte appears once the step counter and then the output byte register are loaded. Busy falls
// during the checksum step, so a following request is taken then and its
// packet follows the previous one with no gap. device_id is written through
// the APB port at byte address 0 and must only be changed while idle.
module servo_write_packet_framer_unit
   import swpf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // Request channel
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [7:0]        req_reg_address,
   input  wire logic [2:0]        req_data_count,
   input  wire logic [7:0]        req_data_byte_0,
   input  wire logic [7:0]        req_data_byte_1,
   input  wire logic [7:0]        req_data_byte_2,
   input  wire logic [7:0]        req_data_byte_3,
   // Result channel
   output logic                   rsp_valid,
   output logic      [7:0]        rsp_packet_byte,
   output logic                   rsp_last_byte,
   // Configuration port
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   logic [7:0]  device_id;
   logic [7:0]  req_data [DATA_FIELDS];
   flags_type   flags;
   dp_ctrl_type ctrl;

   assign req_data[0] = req_data_byte_0;
   assign req_data[1] = req_data_byte_1;
   assign req_data[2] = req_data_byte_2;
   assign req_data[3] = req_data_byte_3;

   swpf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .device_id (device_id)
   );

   // The sequencer walks the packet program; the datapath only follows it.
   swpf_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .busy  (busy),
      .ctrl  (ctrl)
   );

   swpf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .device_id       (device_id),
      .req_reg_address (req_reg_address),
      .req_data_count  (req_data_count),
      .req_data        (req_data),
      .flags           (flags),
      .rsp_valid       (rsp_valid),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_last_byte   (rsp_last_byte)
   );

endmodule

`default_nettype wire

FILE: rtl/core/swpf_csr.sv
// Configuration register file of the servo write packet framer (device_id).
// Depends on swpf_pkg.
`default_nettype none

module swpf_csr
   import swpf_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output logic      [7:0]        device_id
);

   logic [7:0] device_id_ff;
   logic [7:0] device_id_in;
   logic       hit;

   assign hit = (paddr[2] == REG_DEVICE_ID);

   always_comb begin
      device_id_in = device_id_ff;
      if (psel && penable && pwrite && hit) begin
         device_id_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= DEVICE_ID_RESET;
      end else begin
         device_id_ff <= device_id_in;
      end
   end

   assign prdata    = hit ? {24'd0, device_id_ff} : 32'd0;
   assign pready    = 1'b1;
   assign device_id = device_id_ff;

endmodule

`default_nettype wire

FILE: rtl/core/swpf_sequencer.sv
// Step counter and microcode fetch of the servo write packet framer.
// Depends on swpf_pkg.
`default_nettype none

module swpf_sequencer
   import swpf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire flags_type   flags,
   output logic             busy,
   output dp_ctrl_type      ctrl
);

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              running_ff;
   logic              running_in;
   ucode_type         uc;
   logic              accept;

   assign uc     = ucode_rom(step_ff);
   // The checksum step frees the block, so the next request overlaps it.
   assign busy   = running_ff && (uc.branch != BR_END);
   assign accept = start && !busy;

   always_comb begin
      step_in    = step_ff;
      running_in = running_ff;
      if (accept) begin
         step_in    = '0;
         running_in = 1'b1;
      end else if (running_ff) begin
         case (uc.branch)
            BR_NEXT:       step_in = step_ff + 3'd1;
            BR_SKIP_EMPTY: step_in = flags.no_data ? uc.target : step_ff + 3'd1;
            BR_LOOP:       step_in = flags.more_data ? uc.target : step_ff + 3'd1;
            BR_END:        running_in = 1'b0;
            default:       running_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         running_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         running_ff <= running_in;
      end
   end

   assign ctrl.load = accept;
   assign ctrl.run  = running_ff;
   assign ctrl.uc   = uc;

endmodule

`default_nettype wire

FILE: rtl/core/swpf_datapath.sv
// Request registers, checksum accumulator and byte output of the packet framer.
// Depends on swpf_pkg.
`default_nettype none

module swpf_datapath
   import swpf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire dp_ctrl_type ctrl,
   input  wire logic [7:0]  device_id,
   input  wire logic [7:0]  req_reg_address,
   input  wire logic [2:0]  req_data_count,
   input  wire logic [7:0]  req_data [DATA_FIELDS],
   output flags_type        flags,
   output logic             rsp_valid,
   output logic [7:0]       rsp_packet_byte,
   output logic             rsp_last_byte
);

   logic [7:0]       addr_ff;
   logic [7:0]       len_ff;
   logic [CNT_W-1:0] remain_ff;
   logic [7:0]       data_ff [MAX_DATA];
   logic [7:0]       sum_ff;
   logic [7:0]       sum_in;
   logic [7:0]       byte_in;
   logic [CNT_W-1:0] count_sat;
   logic             data_step;
   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   assign count_sat = sat_count(req_data_count);
   assign data_step = ctrl.run && (ctrl.uc.sel == SEL_DATA);

   always_comb begin
      case (ctrl.uc.sel)
         SEL_HDR:   byte_in = HDR_BYTE;
         SEL_ID:    byte_in = device_id;
         SEL_LEN:   byte_in = len_ff;
         SEL_INSTR: byte_in = WRITE_INSTR;
         SEL_ADDR:  byte_in = addr_ff;
         SEL_DATA:  byte_in = data_ff[0];
         SEL_CSUM:  byte_in = ~sum_ff;
         default:   byte_in = ~sum_ff;
      endcase
   end

   always_comb begin
      case (ctrl.uc.sum_op)
         SUM_LOAD: sum_in = byte_in;
         SUM_ADD:  sum_in = sum_ff + byte_in;
         default:  sum_in = sum_ff;
      endcase
   end

   assign flags.no_data   = (remain_ff == '0);
   assign flags.more_data = (remain_ff > CNT_W'(1));

   // Data bytes shift toward slot 0 as they are sent.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         addr_ff   <= req_reg_address;
         len_ff    <= 8'(count_sat) + LEN_OVERHEAD;
         remain_ff <= count_sat;
         for (int i = 0; i < MAX_DATA; i++) begin
            data_ff[i] <= (i < DATA_FIELDS) ? req_data[i % DATA_FIELDS] : 8'd0;
         end
      end else if (data_step) begin
         remain_ff <= remain_ff - CNT_W'(1);
         for (int i = 0; i < MAX_DATA - 1; i++) begin
            data_ff[i] <= data_ff[i+1];
         end
         data_ff[MAX_DATA-1] <= 8'd0;
      end
      if (ctrl.run) begin
         sum_ff      <= sum_in;
         rsp_byte_ff <= byte_in;
         rsp_last_ff <= ctrl.uc.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.run;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = rsp_byte_ff;
   assign rsp_last_byte   = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/swpf_checker.sv
// Port-level checks of the servo write packet framer and their bind.
// Depends on swpf_pkg and servo_write_packet_framer_unit_assert.svh.
`default_nettype none
`include "servo_write_packet_framer_unit_assert.svh"

module swpf_checker
   import swpf_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire logic [7:0]        rsp_packet_byte,
   input wire logic              rsp_last_byte
);

   // A taken request opens its packet with a header beat once the step counter and the output byte register are loaded.
   `SWPF_ASSERT_IMPL(a_header_follows_start, clock, reset, start && !busy, ##2 (rsp_valid && rsp_packet_byte == HDR_BYTE && !rsp_last_byte))

   // Beats of one packet come without gaps until the checksum.
   `SWPF_ASSERT_NEXT(a_packet_contiguous, clock, reset, rsp_valid && !rsp_last_byte, rsp_valid)

   // The beat stream only stops after a checksum beat.
   `SWPF_ASSERT_IMPL(a_stop_after_last, clock, reset, $fell(rsp_valid) && !$past(reset), $past(rsp_last_byte))

   // A packet still being sent holds off new requests until its checksum step.
   `SWPF_ASSERT_NEXT(a_busy_while_sending, clock, reset, rsp_valid && rsp_packet_byte == HDR_BYTE && !rsp_last_byte && $past(start && !busy, 2), busy)

endmodule

bind servo_write_packet_framer_unit swpf_checker u_checker (.*);

`default_nettype wire
